// ===== src/wrm_pkg.sv =====
// Shared types, widths and constants of the windowed RMS meter.
package wrm_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int SUM_BITS      = 40;
  localparam int CNT_BITS      = 8;
  localparam int DIVISOR_BITS  = CNT_BITS + 1;
  localparam int GAIN_BITS     = 16;
  localparam int RMS_BITS      = 17;
  localparam int FRAC_SHIFT    = 16;
  localparam int SRC_BITS      = SUM_BITS + FRAC_SHIFT;
  localparam int ROOT_BITS     = SRC_BITS / 2;
  localparam int SREM_BITS     = ROOT_BITS + 1;
  localparam int PROD_BITS     = ROOT_BITS + GAIN_BITS;
  localparam int OUT_SHIFT     = 20;
  localparam int STEP_BITS     = $clog2(SUM_BITS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = 12'd2048;
  localparam logic [CNT_BITS-1:0]    FRAMES_RESET = 8'd100;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd1650;
  localparam logic [RMS_BITS-1:0]    RMS_MAX      = '1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   frame_end;
  } smp_word_t;

  typedef struct packed {
    logic [RMS_BITS-1:0] rms_value;
    logic                window_done;
  } res_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ADD,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic square;
    logic add;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic mul;
    logic finish;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic close;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/wrm_ctrl.sv =====
// Sequencer of the windowed RMS meter: accumulate, divide, root, scale, emit.
module wrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              smp_valid,
  output logic              smp_ready,
  input  wrm_pkg::dp_stat_t stat,
  output wrm_pkg::dp_cmd_t  cmd
);

  wrm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wrm_pkg::ST_IDLE: begin
        if (smp_valid) state_next = wrm_pkg::ST_SQR;
      end
      wrm_pkg::ST_SQR: state_next = wrm_pkg::ST_ADD;
      wrm_pkg::ST_ADD: begin
        if (stat.close) begin
          state_next = wrm_pkg::ST_DIV_LOAD;
        end else if (stat.frame_end) begin
          state_next = wrm_pkg::ST_OUT;
        end else begin
          state_next = wrm_pkg::ST_IDLE;
        end
      end
      wrm_pkg::ST_DIV_LOAD: state_next = wrm_pkg::ST_DIV;
      wrm_pkg::ST_DIV: begin
        if (stat.div_last) state_next = wrm_pkg::ST_SQRT_LOAD;
      end
      wrm_pkg::ST_SQRT_LOAD: state_next = wrm_pkg::ST_SQRT;
      wrm_pkg::ST_SQRT: begin
        if (stat.sqrt_last) state_next = wrm_pkg::ST_MUL;
      end
      wrm_pkg::ST_MUL: state_next = wrm_pkg::ST_FIN;
      wrm_pkg::ST_FIN: state_next = wrm_pkg::ST_OUT;
      wrm_pkg::ST_OUT: begin
        if (stat.out_free) state_next = wrm_pkg::ST_IDLE;
      end
      default: state_next = wrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    smp_ready = 1'b0;
    case (state)
      wrm_pkg::ST_IDLE: begin
        smp_ready = 1'b1;
        cmd.take  = smp_valid;
      end
      wrm_pkg::ST_SQR:       cmd.square    = 1'b1;
      wrm_pkg::ST_ADD:       cmd.add       = 1'b1;
      wrm_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      wrm_pkg::ST_DIV:       cmd.div_step  = 1'b1;
      wrm_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      wrm_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
      wrm_pkg::ST_MUL:       cmd.mul       = 1'b1;
      wrm_pkg::ST_FIN:       cmd.finish    = 1'b1;
      wrm_pkg::ST_OUT:       cmd.out_load  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/wrm_dp.sv =====
// Datapath of the windowed RMS meter: accumulator, divider, square root, scaler, output word.
module wrm_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  wrm_pkg::smp_word_t                 smp_word,
  output wrm_pkg::res_word_t                 res_word,
  output logic                               res_valid,
  input  logic                               res_ready,
  input  logic                               cfg_we,
  input  logic [wrm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wrm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wrm_pkg::dp_cmd_t                   cmd,
  output wrm_pkg::dp_stat_t                  stat
);

  logic [wrm_pkg::SAMPLE_BITS-1:0]  center;
  logic [wrm_pkg::CNT_BITS-1:0]     frames;
  logic [wrm_pkg::GAIN_BITS-1:0]    gain;

  logic [wrm_pkg::SAMPLE_BITS-1:0]  smp;
  logic                             fend;
  logic [wrm_pkg::SQ_BITS-1:0]      sq;
  logic [wrm_pkg::SUM_BITS-1:0]     sum;
  logic [wrm_pkg::CNT_BITS-1:0]     count;
  logic                             closed;
  logic [wrm_pkg::RMS_BITS-1:0]     held;

  logic [wrm_pkg::DIVISOR_BITS-1:0] divisor;
  logic [wrm_pkg::DIVISOR_BITS-1:0] div_rem;
  logic [wrm_pkg::SUM_BITS-1:0]     quo;
  logic [wrm_pkg::SRC_BITS-1:0]     src;
  logic [wrm_pkg::SREM_BITS-1:0]    sq_rem;
  logic [wrm_pkg::ROOT_BITS-1:0]    root;
  logic [wrm_pkg::PROD_BITS-1:0]    prod;
  logic [wrm_pkg::STEP_BITS-1:0]    step;

  logic [wrm_pkg::SAMPLE_BITS-1:0]  mag;
  logic [wrm_pkg::SUM_BITS:0]       sum_wide;
  logic [wrm_pkg::CNT_BITS-1:0]     count_inc;
  logic [wrm_pkg::DIVISOR_BITS:0]   div_trial;
  logic                             div_ge;
  logic [wrm_pkg::SREM_BITS+1:0]    sq_trial;
  logic [wrm_pkg::SREM_BITS+1:0]    sq_test;
  logic                             sq_ge;
  logic [wrm_pkg::PROD_BITS-wrm_pkg::OUT_SHIFT-1:0] scaled;

  assign mag       = (smp >= center) ? (smp - center) : (center - smp);
  assign sum_wide  = {1'b0, sum} + (wrm_pkg::SUM_BITS+1)'(sq);
  assign count_inc = count + 1'b1;
  assign div_trial = {div_rem, quo[wrm_pkg::SUM_BITS-1]};
  assign div_ge    = div_trial >= {1'b0, divisor};
  assign sq_trial  = {sq_rem, src[wrm_pkg::SRC_BITS-1 -: 2]};
  assign sq_test   = (wrm_pkg::SREM_BITS+2)'({root, 2'b01});
  assign sq_ge     = sq_trial >= sq_test;
  assign scaled    = prod[wrm_pkg::PROD_BITS-1:wrm_pkg::OUT_SHIFT];

  assign stat.frame_end = fend;
  assign stat.close     = fend && (count_inc == frames);
  assign stat.div_last  = step == wrm_pkg::STEP_BITS'(wrm_pkg::SUM_BITS - 1);
  assign stat.sqrt_last = step == wrm_pkg::STEP_BITS'(wrm_pkg::ROOT_BITS - 1);
  assign stat.out_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= wrm_pkg::CENTER_RESET;
      frames <= wrm_pkg::FRAMES_RESET;
      gain   <= wrm_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wrm_pkg::CFG_CENTER: center <= cfg_data[wrm_pkg::SAMPLE_BITS-1:0];
        wrm_pkg::CFG_FRAMES: frames <= cfg_data[wrm_pkg::CNT_BITS-1:0];
        wrm_pkg::CFG_GAIN:   gain   <= cfg_data[wrm_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      held      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.add) begin
        sum <= sum_wide[wrm_pkg::SUM_BITS] ? '1 : sum_wide[wrm_pkg::SUM_BITS-1:0];
        if (fend) count <= count_inc;
      end
      if (cmd.finish) begin
        held  <= (|scaled[$high(scaled):wrm_pkg::RMS_BITS]) ? wrm_pkg::RMS_MAX
                 : scaled[wrm_pkg::RMS_BITS-1:0];
        sum   <= '0;
        count <= '0;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp  <= smp_word.sample;
      fend <= smp_word.frame_end;
    end
    if (cmd.square) sq <= mag * mag;
    if (cmd.add) closed <= stat.close;
    if (cmd.div_load) begin
      divisor <= (count == '0) ? {1'b1, count} : {1'b0, count};
      div_rem <= '0;
      quo     <= sum;
      step    <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? wrm_pkg::DIVISOR_BITS'(div_trial - {1'b0, divisor})
                        : div_trial[wrm_pkg::DIVISOR_BITS-1:0];
      quo     <= {quo[wrm_pkg::SUM_BITS-2:0], div_ge};
      step    <= step + 1'b1;
    end
    if (cmd.sqrt_load) begin
      src    <= {quo, wrm_pkg::FRAC_SHIFT'(0)};
      sq_rem <= '0;
      root   <= '0;
      step   <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_rem <= sq_ge ? wrm_pkg::SREM_BITS'(sq_trial - sq_test)
                      : sq_trial[wrm_pkg::SREM_BITS-1:0];
      root   <= {root[wrm_pkg::ROOT_BITS-2:0], sq_ge};
      src    <= {src[wrm_pkg::SRC_BITS-3:0], 2'b00};
      step   <= step + 1'b1;
    end
    if (cmd.mul) prod <= wrm_pkg::PROD_BITS'(root) * wrm_pkg::PROD_BITS'(gain);
    if (cmd.out_load) begin
      res_word.rms_value   <= held;
      res_word.window_done <= closed;
    end
  end

endmodule

// ===== src/windowed_rms_meter.sv =====
// Sample word: accepted in idle, then squared and added before the next word is taken.
// Frame-end word without window close: squared and added, then the result is registered in output.
// Window close: a restoring divide, a bit-wise square root and the load, multiply, saturate and
// output steps follow the add before the next word is taken; the divide loop is the longest.
// A stalled result word holds the meter in output. Synchronous active-high reset clears the
// accumulator, frame count, held value and output valid flag and restores register defaults.
module windowed_rms_meter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               smp_valid,
  output logic                               smp_ready,
  input  wrm_pkg::smp_word_t                 smp_word,
  output logic                               res_valid,
  input  logic                               res_ready,
  output wrm_pkg::res_word_t                 res_word,
  input  logic                               cfg_we,
  input  logic [wrm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wrm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wrm_pkg::dp_cmd_t  cmd;
  wrm_pkg::dp_stat_t stat;

  wrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wrm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .smp_word  (smp_word),
    .res_word  (res_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/wrm_checker.sv =====
// Port-level checks of the windowed RMS meter and their binding.
module wrm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               smp_valid,
  input logic                               smp_ready,
  input wrm_pkg::smp_word_t                 smp_word,
  input logic                               res_valid,
  input logic                               res_ready,
  input wrm_pkg::res_word_t                 res_word
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> smp_ready && !res_valid)
    else $error("reset did not leave the meter idle and empty");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_word))
    else $error("stalled result word changed or dropped");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready |=> !smp_ready)
    else $error("sample word taken while the previous one is in work");

  a_no_spurious_res: assert property (@(posedge clk) disable iff (rst)
    smp_valid && smp_ready && !smp_word.frame_end && !res_valid
    |=> !res_valid ##1 !res_valid ##1 !res_valid)
    else $error("result word produced without a frame end");

endmodule

bind windowed_rms_meter wrm_checker u_wrm_checker (
  .clk       (clk),
  .rst       (rst),
  .smp_valid (smp_valid),
  .smp_ready (smp_ready),
  .smp_word  (smp_word),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_word  (res_word)
);

// ===== tb/tb_windowed_rms_meter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for windowed_rms_meter with a cycle-free predictor of the RMS windows.
module tb_windowed_rms_meter;

  localparam int IDLE_MAX         = 17;
  localparam int SETTLE_CYCLES    = 100;
  localparam int STALL_LIMIT      = 4000;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_WORDS      = 130;
  localparam int LONG_FRAME_WORDS = 59;
  localparam logic [wrm_pkg::SUM_BITS-1:0] SUM_FULL = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic smp_valid = 1'b0;
  logic smp_ready;
  wrm_pkg::smp_word_t smp_word = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  wrm_pkg::res_word_t res_word;
  logic cfg_we = 1'b0;
  logic [wrm_pkg::CFG_IDX_BITS-1:0] cfg_index = wrm_pkg::CFG_CENTER;
  logic [wrm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  logic [wrm_pkg::SAMPLE_BITS-1:0] m_center = wrm_pkg::CENTER_RESET;
  logic [wrm_pkg::CNT_BITS-1:0]    m_frames = wrm_pkg::FRAMES_RESET;
  logic [wrm_pkg::GAIN_BITS-1:0]   m_gain   = wrm_pkg::GAIN_RESET;
  logic [wrm_pkg::SUM_BITS-1:0]    sq_sum   = '0;
  logic [wrm_pkg::CNT_BITS-1:0]    frm_cnt  = '0;
  logic [wrm_pkg::RMS_BITS-1:0]    held     = '0;

  wrm_pkg::res_word_t due_readings[$];
  int errors = 0;
  int stall_cycles = 0;
  bit send_gaps = 1'b1;
  bit take_gaps = 1'b1;
  int take_hold = 0;

  windowed_rms_meter dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_word  (smp_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [wrm_pkg::ROOT_BITS-1:0] floor_root(
    input logic [wrm_pkg::SRC_BITS-1:0] v);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] b;
    rem = 64'(v);
    acc = '0;
    b = 64'd1 << (wrm_pkg::SRC_BITS - 2);
    repeat (wrm_pkg::ROOT_BITS) begin
      if (rem >= acc + b) begin
        rem = rem - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc[wrm_pkg::ROOT_BITS-1:0];
  endfunction

  task automatic track_rms_window(input wrm_pkg::smp_word_t w);
    logic [wrm_pkg::SAMPLE_BITS-1:0] mag;
    logic [wrm_pkg::SQ_BITS-1:0] sq;
    logic [wrm_pkg::SUM_BITS:0] total;
    logic [wrm_pkg::SUM_BITS-1:0] quot;
    logic [wrm_pkg::DIVISOR_BITS-1:0] divisor;
    logic [wrm_pkg::ROOT_BITS-1:0] root;
    logic [wrm_pkg::PROD_BITS-1:0] prod;
    logic [wrm_pkg::PROD_BITS-wrm_pkg::OUT_SHIFT-1:0] scaled;
    wrm_pkg::res_word_t r;
    mag = (w.sample >= m_center) ? w.sample - m_center : m_center - w.sample;
    sq = wrm_pkg::SQ_BITS'(mag) * wrm_pkg::SQ_BITS'(mag);
    total = {1'b0, sq_sum} + (wrm_pkg::SUM_BITS + 1)'(sq);
    sq_sum = total[wrm_pkg::SUM_BITS] ? SUM_FULL : total[wrm_pkg::SUM_BITS-1:0];
    if (w.frame_end) begin
      frm_cnt = frm_cnt + 1'b1;
      r.window_done = (frm_cnt == m_frames);
      if (r.window_done) begin
        divisor = (frm_cnt == '0) ? wrm_pkg::DIVISOR_BITS'(256)
                                  : wrm_pkg::DIVISOR_BITS'(frm_cnt);
        quot = sq_sum / divisor;
        root = floor_root({quot, {wrm_pkg::FRAC_SHIFT{1'b0}}});
        prod = wrm_pkg::PROD_BITS'(root) * wrm_pkg::PROD_BITS'(m_gain);
        scaled = prod[wrm_pkg::PROD_BITS-1:wrm_pkg::OUT_SHIFT];
        held = (scaled > wrm_pkg::RMS_MAX) ? wrm_pkg::RMS_MAX
                                           : scaled[wrm_pkg::RMS_BITS-1:0];
        sq_sum = '0;
        frm_cnt = '0;
      end
      r.rms_value = held;
      due_readings.push_back(r);
    end
  endtask

  task automatic send_sample(input logic [wrm_pkg::SAMPLE_BITS-1:0] s, input logic fe);
    int gap;
    wrm_pkg::smp_word_t w;
    gap = send_gaps ? $urandom_range(0, IDLE_MAX) : 0;
    w.sample = s;
    w.frame_end = fe;
    if (gap > 0) begin
      @(negedge clk);
      smp_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    smp_valid <= 1'b1;
    smp_word <= w;
    do @(posedge clk); while (!smp_ready);
    track_rms_window(w);
  endtask

  task automatic settle;
    @(negedge clk);
    smp_valid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wrm_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [wrm_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      wrm_pkg::CFG_CENTER: m_center = data[wrm_pkg::SAMPLE_BITS-1:0];
      wrm_pkg::CFG_FRAMES: m_frames = data[wrm_pkg::CNT_BITS-1:0];
      wrm_pkg::CFG_GAIN:   m_gain = data[wrm_pkg::GAIN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_meter(input int center, input int frames, input int gain);
    write_reg(wrm_pkg::CFG_CENTER, wrm_pkg::CFG_DATA_BITS'(center));
    write_reg(wrm_pkg::CFG_FRAMES, wrm_pkg::CFG_DATA_BITS'(frames));
    write_reg(wrm_pkg::CFG_GAIN, wrm_pkg::CFG_DATA_BITS'(gain));
  endtask

  function automatic logic [wrm_pkg::SAMPLE_BITS-1:0] pick_sample();
    int d;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: begin
        d = int'(m_center) + int'($urandom_range(0, 32)) - 16;
        if (d < 0) d = 0;
        if (d > 4095) d = 4095;
        return wrm_pkg::SAMPLE_BITS'(d);
      end
      default: return wrm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic test_power_on_values;
    send_sample(12'd2048, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
    settle;
  endtask

  task automatic test_directed_corners;
    set_meter(0, 3, 65535);
    send_sample(12'd4095, 1'b1);
    settle;
    write_reg(wrm_pkg::CFG_FRAMES, 16'd1);
    for (int i = 0; i < 8; i++) send_sample(12'd4095, i == 7);
    settle;
    write_reg(wrm_pkg::CFG_GAIN, 16'd0);
    send_sample(12'd4095, 1'b1);
    settle;
    set_meter(4095, 1, 1650);
    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b1);
    settle;
    write_reg(wrm_pkg::CFG_FRAMES, 16'd2);
    send_sample(12'd100, 1'b1);
    send_sample(12'd3000, 1'b1);
    settle;
  endtask

  task automatic test_frame_count_wrap;
    set_meter($urandom_range(0, 4095), 0, $urandom_range(0, 65535));
    repeat (256) send_frame(1);
    settle;
  endtask

  task automatic test_window_lowered;
    write_reg(wrm_pkg::CFG_FRAMES, 16'd20);
    repeat (10) send_frame(1);
    settle;
    write_reg(wrm_pkg::CFG_FRAMES, 16'd4);
    repeat (250) send_frame(1);
    settle;
  endtask

  task automatic test_long_frame;
    set_meter(0, 1, 300);
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    repeat (LONG_FRAME_WORDS) send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    settle;
    send_gaps = 1'b1;
    take_gaps = 1'b1;
  endtask

  task automatic test_backpressure;
    set_meter($urandom_range(0, 4095), 2, 1650);
    take_hold = HOLD_CYCLES;
    repeat (40) send_frame(1);
    settle;
    repeat (20) send_frame($urandom_range(1, 3));
    settle;
  endtask

  task automatic test_random_windows;
    int sent;
    int len;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_meter(ph == 0 ? 0 : ph == 1 ? 4095 : $urandom_range(0, 4095),
                ph == 2 ? 255 : ph == 3 ? 1 : $urandom_range(1, 6),
                ph == 4 ? 0 : ph == 5 ? 65535 : $urandom_range(0, 65535));
      send_gaps = (ph % 3) != 2;
      take_gaps = (ph % 4) != 3;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 5);
        send_frame(len);
        sent += len;
      end
      settle;
    end
    send_gaps = 1'b1;
    take_gaps = 1'b1;
  endtask

  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (take_hold > 0) begin
        @(negedge clk);
        res_ready <= 1'b0;
        repeat (take_hold - 1) @(negedge clk);
        take_hold = 0;
      end
      gap = take_gaps ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
        @(negedge clk);
        res_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  always @(posedge clk) begin
    wrm_pkg::res_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (due_readings.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual rms_value %0d window_done %0d",
                 $time, res_word.rms_value, res_word.window_done);
      end else begin
        want = due_readings.pop_front();
        if (res_word.rms_value !== want.rms_value) begin
          errors++;
          $display("%0t rms_value: expected %0d, actual %0d",
                   $time, want.rms_value, res_word.rms_value);
        end
        if (res_word.window_done !== want.window_done) begin
          errors++;
          $display("%0t window_done: expected %0d, actual %0d",
                   $time, want.window_done, res_word.window_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp_valid && smp_ready) || (res_valid && res_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_windowed_rms_meter: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_power_on_values;
    test_directed_corners;
    test_frame_count_wrap;
    test_window_lowered;
    test_long_frame;
    test_backpressure;
    test_random_windows;
    settle;
    if (errors == 0) $display("tb_windowed_rms_meter: clean");
    else $display("tb_windowed_rms_meter: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wrm_pkg.sv
src/wrm_ctrl.sv
src/wrm_dp.sv
src/windowed_rms_meter.sv
src/wrm_checker.sv
tb/tb_windowed_rms_meter.sv
